// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the line assembler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TLA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TLA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tla_pkg.sv =====
// Types and constants shared by the Telnet line assembler modules.
`timescale 1ns / 1ps
package tla_pkg;

  // Size of the line buffer; writes stop two short of it.
  localparam int LINE_SIZE = 256;
  localparam logic [7:0] LINE_LIMIT = 8'(LINE_SIZE - 2);

  // Telnet command codes.
  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_EL   = 8'd248;
  localparam logic [7:0] CODE_EC   = 8'd247;
  localparam logic [7:0] CODE_DM   = 8'd242;

  // Plain characters with special meaning.
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_LINEND = 2'd1,
    ACT_REFUSE = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0] line_length;
    logic       command_pending;
    logic       option_pending;
    logic       option_was_do;
    logic       carriage_return_seen;
    logic       urgent_mode;
  } tla_state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] out_byte;
    logic [7:0] position;
    logic       refuse_do;
  } tla_result_t;

endpackage

// ===== rtl/core/tla_in_stage.sv =====
// Input register that holds one received byte until the decoder takes it.
`timescale 1ns / 1ps
module tla_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] rx_byte_in,
  input  logic       urgent_in,
  input  logic       advance,
  output logic       valid,
  output logic [7:0] rx_byte,
  output logic       urgent_active
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte       <= rx_byte_in;
      urgent_active <= urgent_in;
    end
  end

endmodule

// ===== rtl/core/tla_decode.sv =====
// Combinational decoder: one received byte and the current state give the next
// state and at most one result.
`timescale 1ns / 1ps
module tla_decode (
  input  tla_pkg::tla_state_t  state,
  input  logic [7:0]           rx_byte,
  input  logic                 urgent_active,
  output tla_pkg::tla_state_t  state_next,
  output logic                 has_result,
  output tla_pkg::tla_result_t result
);
  import tla_pkg::*;

  logic room;

  assign room = state.line_length < LINE_LIMIT;

  always_comb begin
    state_next = state;
    has_result = 1'b0;
    result     = '0;

    priority if (state.option_pending) begin
      // The byte after DO or WILL is the option code, whatever it is.
      state_next.option_pending = 1'b0;
      has_result       = 1'b1;
      result.action    = ACT_REFUSE;
      result.out_byte  = rx_byte;
      result.refuse_do = state.option_was_do;
    end else if (state.command_pending) begin
      state_next.command_pending = 1'b0;
      if (rx_byte == CODE_DM) begin
        state_next.urgent_mode = urgent_active;
        state_next.line_length = '0;
      end else if (!state.urgent_mode) begin
        unique case (rx_byte)
          CODE_EC: begin
            if (state.line_length != '0) begin
              state_next.line_length = state.line_length - 8'd1;
            end
          end
          CODE_EL: begin
            state_next.line_length = '0;
          end
          CODE_DO, CODE_WILL: begin
            state_next.option_pending = 1'b1;
            state_next.option_was_do  = (rx_byte == CODE_DO);
          end
          CODE_IAC: begin
            if (room) begin
              has_result             = 1'b1;
              result.action          = ACT_WRITE;
              result.out_byte        = CODE_IAC;
              result.position        = state.line_length;
              state_next.line_length = state.line_length + 8'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (rx_byte == CODE_IAC) begin
      state_next.command_pending = 1'b1;
    end else if (!state.urgent_mode) begin
      unique case (rx_byte)
        CHAR_CR: begin
          state_next.carriage_return_seen = 1'b1;
        end
        CHAR_LF: begin
          has_result                      = 1'b1;
          result.action                   = ACT_LINEND;
          result.out_byte                 = CHAR_LF;
          result.position                 = state.line_length;
          state_next.line_length          = '0;
          state_next.carriage_return_seen = 1'b0;
        end
        CHAR_NUL: begin
          if (state.carriage_return_seen) begin
            state_next.carriage_return_seen = 1'b0;
            if (room) begin
              has_result             = 1'b1;
              result.action          = ACT_WRITE;
              result.out_byte        = CHAR_CR;
              result.position        = state.line_length;
              state_next.line_length = state.line_length + 8'd1;
            end
          end
        end
        default: begin
          state_next.carriage_return_seen = 1'b0;
          if (room) begin
            has_result             = 1'b1;
            result.action          = ACT_WRITE;
            result.out_byte        = rx_byte;
            result.position        = state.line_length;
            state_next.line_length = state.line_length + 8'd1;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tla_out_stage.sv =====
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
module tla_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tla_pkg::tla_result_t result,
  output logic                 free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,
  output logic [2:0]           m_tuser
);
  import tla_pkg::*;

  tla_result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.position, held.out_byte};
  assign m_tuser = {held.refuse_do, held.action};

endmodule

// ===== rtl/core/telnet_line_assembler.sv =====
// Top level of the Telnet receive line assembler.
//
//   Channel   Direction  tdata                            tuser
//   s_*       in         [7:0] rx_byte                    [0] urgent_active
//   m_*       out        [7:0] out_byte, [15:8] position  [1:0] action, [2] refuse_do
//
// One request is taken in every cycle unless a stalled result fills both registers.
// The input register takes a request when it is accepted, and the result register
// takes its result from the decoder once it is free.
// The decision itself is one pass of shallow logic on a handful of flags.
// Reset (rst, synchronous, active high) empties both registers and clears the
// line length and all command, option, carriage-return and urgent flags.
// A stalled result holds the result register; a request already in the input
// register then waits there, and s_tready falls only once both are occupied.
// Requests that give no result leave the output side alone, though they too
// wait while a result is stalled.
`timescale 1ns / 1ps
module telnet_line_assembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] urgent_active
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] position
  output logic [2:0]  m_tuser    // [1:0] action, [2] refuse_do
);
  import tla_pkg::*;

  // Request held in the input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_urgent;

  // Decoder state and its update.
  tla_state_t  state;
  tla_state_t  state_next;
  logic        has_result;
  tla_result_t result;

  // The held request is consumed when the result register can take its result.
  logic out_free;
  logic advance;

  assign advance = in_valid && out_free;

  tla_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .rx_byte_in    (s_tdata),
    .urgent_in     (s_tuser[0]),
    .advance       (advance),
    .valid         (in_valid),
    .rx_byte       (in_byte),
    .urgent_active (in_urgent)
  );

  tla_decode u_dec (
    .state         (state),
    .rx_byte       (in_byte),
    .urgent_active (in_urgent),
    .state_next    (state_next),
    .has_result    (has_result),
    .result        (result)
  );

  // The line state moves only when a request is actually consumed, so a
  // stalled output never lets a byte be decoded twice.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  tla_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_result),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/tla_checker.sv =====
// Port-level checks on the result stream of the line assembler, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tla_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import tla_pkg::*;

  logic        is_write;
  logic        is_linend;
  logic        is_refuse;
  logic        action_ok;
  logic        shape_ok;
  logic        bounds_ok;
  logic        stalled;
  logic [18:0] beat;

  assign is_write  = m_tuser[1:0] == ACT_WRITE;
  assign is_linend = m_tuser[1:0] == ACT_LINEND;
  assign is_refuse = m_tuser[1:0] == ACT_REFUSE;

  assign action_ok = is_write || is_linend || is_refuse;
  assign shape_ok  = is_refuse ? (m_tdata[15:8] == 8'd0) : !m_tuser[2];
  assign bounds_ok = is_linend ? (m_tdata[7:0] == CHAR_LF) : (m_tdata[15:8] < LINE_LIMIT);
  assign stalled   = m_tvalid && !m_tready;
  assign beat      = {m_tuser, m_tdata};

  // Only the three defined actions ever appear.
  `TLA_ASSERT_IMP(a_action_known, m_tvalid, action_ok, "undefined action")

  // Refusals carry position zero; writes and line ends never ask for WONT.
  `TLA_ASSERT_IMP(a_field_shape, m_tvalid, shape_ok, "bad fields")

  // Writes stay below the limit and line ends always carry LF.
  `TLA_ASSERT_IMP(a_write_bounds, m_tvalid && !is_refuse, bounds_ok, "bad write or line end")

  // A result not taken stays put.
  `TLA_ASSERT_NXT(a_hold, stalled, m_tvalid && $stable(beat), "stalled result changed")

endmodule

bind telnet_line_assembler tla_checker u_tla_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/line_assembler_checker.sv =====
// Checker that predicts the results of the Telnet line assembler and compares them.
`timescale 1ns / 1ps
module line_assembler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] urgent_active
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] position
  input  logic [2:0]  m_tuser,   // [1:0] action, [2] refuse_do
  output int          errors,
  output int          outstanding
);
  import tla_pkg::*;

  // Own copy of the line and command state.
  logic [7:0] kept_len;
  logic       cmd_open;
  logic       opt_open;
  logic       opt_from_do;
  logic       cr_held;
  logic       synch_on;

  tla_result_t pending_results [$];
  tla_result_t got;
  tla_result_t want;
  tla_result_t predicted;
  bit          produced;
  int          mismatch_count;

  function automatic string describe(tla_result_t r);
    return $sformatf("action=%0d byte=%02h position=%0d refuse_do=%0b",
                     r.action, r.out_byte, r.position, r.refuse_do);
  endfunction

  // Writes stop two short of the buffer size; the line end is never held back.
  function automatic void keep_byte(input logic [7:0] b, output bit made,
                                    output tla_result_t r);
    made = 1'b0;
    r = '0;
    if (kept_len < LINE_LIMIT) begin
      r = '{action: ACT_WRITE, out_byte: b, position: kept_len, refuse_do: 1'b0};
      made = 1'b1;
      kept_len = kept_len + 8'd1;
    end
  endfunction

  function automatic void assemble_byte(input logic [7:0] rx, input logic urg,
                                        output bit made, output tla_result_t r);
    made = 1'b0;
    r = '0;
    if (opt_open) begin
      // The byte after DO or WILL is the option code, whatever it is.
      opt_open = 1'b0;
      made = 1'b1;
      r = '{action: ACT_REFUSE, out_byte: rx, position: 8'd0, refuse_do: opt_from_do};
    end else if (cmd_open) begin
      cmd_open = 1'b0;
      if (rx == CODE_DM) begin
        synch_on = urg;
        kept_len = 8'd0;
      end else if (!synch_on) begin
        case (rx)
          CODE_EC:   if (kept_len != 8'd0) kept_len = kept_len - 8'd1;
          CODE_EL:   kept_len = 8'd0;
          CODE_DO, CODE_WILL: begin
            opt_open = 1'b1;
            opt_from_do = (rx == CODE_DO);
          end
          CODE_IAC:  keep_byte(CODE_IAC, made, r);
          default:   ;
        endcase
      end
    end else if (rx == CODE_IAC) begin
      cmd_open = 1'b1;
    end else if (!synch_on) begin
      case (rx)
        CHAR_CR:  cr_held = 1'b1;
        CHAR_LF: begin
          r = '{action: ACT_LINEND, out_byte: CHAR_LF, position: kept_len, refuse_do: 1'b0};
          made = 1'b1;
          kept_len = 8'd0;
          cr_held = 1'b0;
        end
        CHAR_NUL: begin
          if (cr_held) begin
            cr_held = 1'b0;
            keep_byte(CHAR_CR, made, r);
          end
        end
        default: begin
          cr_held = 1'b0;
          keep_byte(rx, made, r);
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kept_len = 8'd0;
      cmd_open = 1'b0;
      opt_open = 1'b0;
      opt_from_do = 1'b0;
      cr_held = 1'b0;
      synch_on = 1'b0;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      // A result cannot leave in the cycle its request enters, so compare first.
      if (m_tvalid && m_tready) begin
        got = '{action: action_t'(m_tuser[1:0]), out_byte: m_tdata[7:0],
                position: m_tdata[15:8], refuse_do: m_tuser[2]};
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t checker: unexpected result %s", $time, describe(got));
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("%0t checker: expected %s, got %s", $time, describe(want),
                       describe(got));
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        assemble_byte(s_tdata, s_tuser[0], produced, predicted);
        if (produced) pending_results.push_back(predicted);
      end
    end
    outstanding <= pending_results.size();
    errors <= mismatch_count;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the testbench: stimulus, receiver stalls and verdict for the line assembler.
`timescale 1ns / 1ps
module testbench;
  import tla_pkg::*;

  // Idling phases; the hold-off of the receiver happens once, in PH_BACKPRESSURE.
  typedef enum int {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH_GAPS,
    PH_BACKPRESSURE
  } phase_t;

  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 500;
  localparam int SETTLE_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
  logic [0:0]  s_tuser = 1'b0;   // [0] urgent_active
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // [7:0] out_byte, [15:8] position
  logic [2:0]  m_tuser;          // [1:0] action, [2] refuse_do
  logic        holding = 1'b0;
  phase_t      phase = PH_BOTH_GAPS;
  int          sent = 0;
  int          errors;
  int          outstanding;

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  telnet_line_assembler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  line_assembler_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Percentage of cycles that one side spends idle in a given phase.
  function automatic int idle_pct(phase_t ph, bit sender_side);
    case (ph)
      PH_SENDER_GAPS:     return sender_side ? 75 : 0;
      PH_RECEIVER_STALLS: return sender_side ? 0 : 75;
      PH_BOTH_GAPS:       return 38;
      default:            return 0;
    endcase
  endfunction

  // The receiver stalls at random, and throughout while the hold-off runs.
  always @(posedge clk) begin
    m_tready <= !holding && ($urandom_range(99) >= idle_pct(phase, 1'b0));
  end

  // A single long hold-off: the sender keeps offering requests, so the block
  // fills both of its registers and has to drop s_tready.
  initial begin
    wait (phase == PH_BACKPRESSURE);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Offers one request and returns at the edge where it is accepted. Idle
  // cycles go before the request, with rubbish on the data lines meanwhile.
  // When no idling is drawn, tvalid simply stays high from the last request.
  task automatic send_request(input logic [7:0] rx, input logic urg);
    if ($urandom_range(99) < idle_pct(phase, 1'b1)) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct(phase, 1'b1));
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    s_tuser  <= urg;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  initial begin
    // Directed requests, urgent flag in the top bit: plain data, a lone NUL,
    // CR NUL, a lone CR, escaped IAC, erase character, erase line, erase on
    // an empty line, refusals of DO and WILL with extreme option codes, then
    // urgent mode with dropped data and a dropped DO, and a line end.
    logic [8:0] warmup [$] = '{
      {1'b0, 8'h41}, {1'b0, CHAR_NUL}, {1'b0, CHAR_CR}, {1'b0, CHAR_NUL},
      {1'b0, CHAR_CR}, {1'b0, 8'h42}, {1'b1, 8'hFE}, {1'b0, 8'h01},
      {1'b0, CODE_IAC}, {1'b0, CODE_IAC}, {1'b0, CODE_IAC}, {1'b0, CODE_EC},
      {1'b0, CODE_IAC}, {1'b0, CODE_EL}, {1'b0, CODE_IAC}, {1'b0, CODE_EC},
      {1'b0, CODE_IAC}, {1'b0, CODE_DO}, {1'b1, 8'h00},
      {1'b0, CODE_IAC}, {1'b0, CODE_WILL}, {1'b0, 8'hFF},
      {1'b0, CODE_IAC}, {1'b1, CODE_DM}, {1'b0, 8'h78}, {1'b0, CHAR_LF},
      {1'b0, CODE_IAC}, {1'b0, CODE_DO}, {1'b0, CODE_IAC}, {1'b0, CODE_DM},
      {1'b0, CHAR_LF}
    };
    int n;
    int kind;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (warmup[i]) send_request(warmup[i][7:0], warmup[i][8]);

    // One line run past the limit: further data, escaped IAC and CR NUL are
    // dropped, erase character makes room for exactly one more byte, and the
    // line end still lands at the last position.
    phase = PH_STEADY;
    n = $urandom_range(254, 262);
    repeat (n) send_request(8'($urandom_range(33, 126)), 1'($urandom_range(1)));
    send_request(CODE_IAC, 1'b0);
    send_request(CODE_IAC, 1'b0);
    send_request(CHAR_CR, 1'b0);
    send_request(CHAR_NUL, 1'b0);
    send_request(CODE_IAC, 1'b0);
    send_request(CODE_EC, 1'b0);
    send_request(8'h7A, 1'b0);
    send_request(8'h79, 1'b0);
    send_request(CHAR_LF, 1'b0);

    // Random part: mostly well-formed Telnet sequences with random content,
    // with some noise and stray commands mixed in.
    while (sent < ITEM_TARGET) begin
      phase = phase_t'((sent / 40) % 5);
      kind = $urandom_range(99);
      if (kind < 35) begin
        n = $urandom_range(1, 12);
        repeat (n) send_request(8'($urandom_range(32, 126)), 1'($urandom_range(1)));
        case ($urandom_range(3))
          0: begin
            send_request(CHAR_CR, 1'($urandom_range(1)));
            send_request(CHAR_LF, 1'($urandom_range(1)));
          end
          1: send_request(CHAR_LF, 1'($urandom_range(1)));
          default: ;
        endcase
      end else if (kind < 45) begin
        send_request(CHAR_CR, 1'($urandom_range(1)));
        send_request(CHAR_NUL, 1'($urandom_range(1)));
      end else if (kind < 52) begin
        send_request(CODE_IAC, 1'($urandom_range(1)));
        send_request(CODE_IAC, 1'($urandom_range(1)));
      end else if (kind < 60) begin
        send_request(CODE_IAC, 1'($urandom_range(1)));
        send_request($urandom_range(1) ? CODE_EC : CODE_EL, 1'($urandom_range(1)));
      end else if (kind < 70) begin
        send_request(CODE_IAC, 1'($urandom_range(1)));
        send_request($urandom_range(1) ? CODE_DO : CODE_WILL, 1'($urandom_range(1)));
        send_request(8'($urandom), 1'($urandom_range(1)));
      end else if (kind < 75) begin
        // Synch: urgent mode on, some bytes that must be dropped, and a second
        // Data Mark that usually finds no more urgent data pending.
        send_request(CODE_IAC, 1'b0);
        send_request(CODE_DM, 1'b1);
        n = $urandom_range(2, 6);
        repeat (n) send_request(8'($urandom_range(0, 254)), 1'($urandom_range(1)));
        send_request(CODE_IAC, 1'b0);
        send_request(CODE_DM, $urandom_range(99) < 20);
      end else if (kind < 80) begin
        send_request(CHAR_CR, 1'($urandom_range(1)));
        send_request(8'($urandom_range(32, 126)), 1'($urandom_range(1)));
      end else if (kind < 88) begin
        send_request(CODE_IAC, 1'($urandom_range(1)));
        send_request(8'($urandom), 1'($urandom_range(1)));
      end else begin
        send_request(8'($urandom), 1'($urandom_range(1)));
      end
    end

    s_tvalid <= 1'b0;
    // Let the registered count of outstanding results take in the last request first.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tla_pkg.sv
rtl/core/tla_in_stage.sv
rtl/core/tla_decode.sv
rtl/core/tla_out_stage.sv
rtl/core/telnet_line_assembler.sv
rtl/core/tla_checker.sv
sim/line_assembler_checker.sv
sim/testbench.sv
